FILE: rtl/core/rtt_estimator_fault_monitor_core_macros.svh
// assertion helpers for the rtt estimator core
`ifndef RTT_ESTIMATOR_FAULT_MONITOR_CORE_MACROS_SVH
`define RTT_ESTIMATOR_FAULT_MONITOR_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define RTT_FM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define RTT_FM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rtt_fm_pkg.sv
package rtt_fm_pkg;

  localparam int TIME_BITS_DEF = 16;

  localparam int KIND_BITS    = 2;
  localparam int SAMPLE_BITS  = 20;
  localparam int SITE_BITS    = 2;
  localparam int CFG_BITS     = 16;
  localparam int OUT_TMO_BITS = 17;
  localparam int CFG_IDX_BITS = 2;

  localparam int S_TDATA_BITS = 24;
  localparam int M_TDATA_BITS = 24;

  localparam logic [KIND_BITS-1:0] KIND_WORKING = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [SITE_BITS-1:0] SITE_OK   = 2'd0;
  localparam logic [SITE_BITS-1:0] SITE_TEMP = 2'd1;
  localparam logic [SITE_BITS-1:0] SITE_PERM = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RTT_UPPER_BOUND = 2'd1;

  localparam logic [CFG_BITS-1:0] INITIAL_TIMEOUT_RST = 16'd5000;
  localparam logic [CFG_BITS-1:0] RTT_UPPER_BOUND_RST = 16'd30000;

endpackage

FILE: rtl/core/rtt_estimator_fault_monitor_core.sv
// path: an input beat is taken into the input register, then its result
//   into the result register, which holds it while the output stalls
// throughput: one event per cycle while the output is not stalled; the estimator
//   state is updated in the same cycle the result register loads, so the next event sees it
// reset (rst, synchronous): clears both pipeline valids, zeroes average and
//   deviation, loads registers and current timeout with their defaults
module rtt_estimator_fault_monitor_core
  import rtt_fm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [S_TDATA_BITS-1:0] s_axis_tdata,   // rtt_sample, site_state
  input  logic [KIND_BITS-1:0]    s_axis_tuser,   // kind
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [M_TDATA_BITS-1:0] m_axis_tdata,   // site_state_next, monitor_timeout
  output logic                    m_axis_tuser,   // monitor_start
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int CW = (TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS;
  localparam int TW = (TIME_BITS + 1 > CFG_BITS) ? TIME_BITS + 1 : CFG_BITS;
  localparam int EW = TIME_BITS + 2;
  localparam logic [CW-1:0] TMAX_C = CW'((64'd1 << TIME_BITS) - 64'd1);

  logic [CFG_BITS-1:0] initial_timeout;
  logic [CFG_BITS-1:0] rtt_upper_bound;

  logic [TIME_BITS-1:0] rtt_average;
  logic [TIME_BITS-1:0] rtt_deviation;
  logic [TW-1:0]        current_timeout;

  logic                   in_valid;
  logic [KIND_BITS-1:0]   in_kind;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [SITE_BITS-1:0]   in_site;

  logic [SITE_BITS-1:0]    out_site;
  logic                    out_start;
  logic [OUT_TMO_BITS-1:0] out_timeout;

  logic advance;

  logic [CW-1:0]        samp_ext;
  logic [CW-1:0]        ub_ext;
  logic [CW-1:0]        clamp_ub;
  logic [CW-1:0]        clamp_max;
  logic [TIME_BITS-1:0] samp_w;

  logic signed [EW-1:0] err;
  logic signed [EW-1:0] err_adj;
  logic signed [EW-1:0] avg_sum;
  logic signed [EW-1:0] abs_err;
  logic signed [EW-1:0] dd;
  logic signed [EW-1:0] dd_adj;
  logic signed [EW-1:0] dev_sum;

  logic [SITE_BITS-1:0] site_next;
  logic                 start_next;
  logic [TIME_BITS-1:0] rtt_average_next;
  logic [TIME_BITS-1:0] rtt_deviation_next;
  logic [TW-1:0]        current_timeout_next;

  assign cfg_ready     = 1'b1;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tdata = {{(M_TDATA_BITS - SITE_BITS - OUT_TMO_BITS){1'b0}}, out_timeout, out_site};
  assign m_axis_tuser = out_start;

  // sample clamp to the upper bound and to the time width
  assign samp_ext  = CW'(in_sample);
  assign ub_ext    = CW'(rtt_upper_bound);
  assign clamp_ub  = (samp_ext > ub_ext) ? ub_ext : samp_ext;
  assign clamp_max = (clamp_ub > TMAX_C) ? TMAX_C : clamp_ub;
  assign samp_w    = clamp_max[TIME_BITS-1:0];

  // smoothed average, gain 1/2, truncating toward zero
  assign err     = $signed({2'b00, samp_w}) - $signed({2'b00, rtt_average});
  assign err_adj = err + $signed({{(EW-1){1'b0}}, err[EW-1]});
  assign avg_sum = $signed({2'b00, rtt_average}) + (err_adj >>> 1);

  // mean deviation, gain 1/4, truncating toward zero
  assign abs_err = err[EW-1] ? -err : err;
  assign dd      = abs_err - $signed({2'b00, rtt_deviation});
  assign dd_adj  = dd + $signed({{(EW-2){1'b0}}, {2{dd[EW-1]}}});
  assign dev_sum = $signed({2'b00, rtt_deviation}) + (dd_adj >>> 2);

  always_comb begin
    site_next            = in_site;
    start_next           = 1'b0;
    rtt_average_next     = rtt_average;
    rtt_deviation_next   = rtt_deviation;
    current_timeout_next = current_timeout;
    case (in_kind)
      KIND_WORKING: begin
        rtt_average_next     = '0;
        current_timeout_next = TW'(initial_timeout);
        start_next           = 1'b1;
      end
      KIND_SAMPLE: begin
        if (in_site inside {SITE_OK, SITE_TEMP}) begin
          site_next  = SITE_OK;
          start_next = 1'b1;
          if (rtt_average != '0) begin
            rtt_average_next   = avg_sum[TIME_BITS-1:0];
            rtt_deviation_next = dev_sum[TIME_BITS-1:0];
          end else begin
            rtt_average_next   = samp_w;
            rtt_deviation_next = samp_w;
          end
          current_timeout_next = TW'(rtt_average_next) + TW'(rtt_deviation_next);
        end
      end
      KIND_TIMEOUT: begin
        if (in_site inside {SITE_OK, SITE_TEMP}) begin
          site_next  = SITE_TEMP;
          start_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_timeout <= INITIAL_TIMEOUT_RST;
      rtt_upper_bound <= RTT_UPPER_BOUND_RST;
      rtt_average     <= '0;
      rtt_deviation   <= '0;
      current_timeout <= TW'(INITIAL_TIMEOUT_RST);
      in_valid        <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INITIAL_TIMEOUT: initial_timeout <= cfg_data;
          REG_RTT_UPPER_BOUND: rtt_upper_bound <= cfg_data;
          default: begin
          end
        endcase
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
        if (in_valid) begin
          rtt_average     <= rtt_average_next;
          rtt_deviation   <= rtt_deviation_next;
          current_timeout <= current_timeout_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind   <= s_axis_tuser;
      in_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
      in_site   <= s_axis_tdata[SAMPLE_BITS+SITE_BITS-1:SAMPLE_BITS];
    end
    if (advance && in_valid) begin
      out_site    <= site_next;
      out_start   <= start_next;
      out_timeout <= start_next ? OUT_TMO_BITS'(current_timeout_next) : '0;
    end
  end

endmodule

FILE: rtl/core/rtt_fm_checker.sv
`include "rtt_estimator_fault_monitor_core_macros.svh"

module rtt_fm_props
  import rtt_fm_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [M_TDATA_BITS-1:0] m_axis_tdata,   // site_state_next, monitor_timeout
  input logic                    m_axis_tuser    // monitor_start
);

  `RTT_FM_ASSERT_IMP(a_idle_timeout_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[SITE_BITS+OUT_TMO_BITS-1:SITE_BITS] == '0, "timeout nonzero without monitor start")

  `RTT_FM_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[M_TDATA_BITS-1:SITE_BITS+OUT_TMO_BITS] == '0, "result padding bits not zero")

  `RTT_FM_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled while output register empty")

  `RTT_FM_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

endmodule

bind rtt_estimator_fault_monitor_core rtt_fm_props u_rtt_fm_props (.*);

FILE: sim/rtt_fm_checker.sv
module rtt_fm_checker
  import rtt_fm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
  input  logic [KIND_BITS-1:0]    s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [M_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                    m_axis_tuser,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output int                      errors,
  output int                      pending,
  output int                      checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_TIME_BITS = TIME_BITS_DEF;
  localparam int TIME_LIMIT = (1 << TB_TIME_BITS) - 1;

  typedef struct packed {
    logic [SITE_BITS-1:0]    site;
    logic                    start;
    logic [OUT_TMO_BITS-1:0] tmo;
  } monitor_result_t;

  logic [CFG_BITS-1:0]     init_tmo;
  logic [CFG_BITS-1:0]     upper_bound;
  logic [TB_TIME_BITS-1:0] avg_rtt;
  logic [TB_TIME_BITS-1:0] dev_rtt;
  logic [TB_TIME_BITS:0]   cur_tmo;
  monitor_result_t         expected_results[$];

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end

  // clamp, then seed or smooth average and deviation
  function automatic void fold_sample(logic [SAMPLE_BITS-1:0] raw);
    int s;
    int err;
    int na;
    int nd;
    s = int'(raw);
    if (s > int'(upper_bound)) s = int'(upper_bound);
    if (s > TIME_LIMIT) s = TIME_LIMIT;
    if (avg_rtt != '0) begin
      err = s - int'(avg_rtt);
      na = int'(avg_rtt) + err / 2;
      nd = int'(dev_rtt) + (((err < 0) ? -err : err) - int'(dev_rtt)) / 4;
      if (na < 0) na = 0;
      if (nd < 0) nd = 0;
      if (na > TIME_LIMIT) na = TIME_LIMIT;
      if (nd > TIME_LIMIT) nd = TIME_LIMIT;
      avg_rtt = na[TB_TIME_BITS-1:0];
      dev_rtt = nd[TB_TIME_BITS-1:0];
    end else begin
      avg_rtt = s[TB_TIME_BITS-1:0];
      dev_rtt = s[TB_TIME_BITS-1:0];
    end
    cur_tmo = {1'b0, avg_rtt} + {1'b0, dev_rtt};
  endfunction

  function automatic monitor_result_t predict_event(logic [KIND_BITS-1:0] kind,
                                                   logic [SAMPLE_BITS-1:0] smp,
                                                   logic [SITE_BITS-1:0] st);
    monitor_result_t r;
    r.site = st;
    r.start = 1'b0;
    case (kind)
      KIND_WORKING: begin
        avg_rtt = '0;
        cur_tmo = {1'b0, init_tmo};
        r.start = 1'b1;
      end
      KIND_SAMPLE: begin
        if (st == SITE_OK || st == SITE_TEMP) begin
          r.site = SITE_OK;
          fold_sample(smp);
          r.start = 1'b1;
        end
      end
      KIND_TIMEOUT: begin
        if (st == SITE_OK || st == SITE_TEMP) begin
          r.site = SITE_TEMP;
          r.start = 1'b1;
        end
      end
      default: ;
    endcase
    r.tmo = r.start ? OUT_TMO_BITS'(cur_tmo) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    monitor_result_t got;
    monitor_result_t want;
    if (rst) begin
      init_tmo = INITIAL_TIMEOUT_RST;
      upper_bound = RTT_UPPER_BOUND_RST;
      avg_rtt = '0;
      dev_rtt = '0;
      cur_tmo = {1'b0, INITIAL_TIMEOUT_RST};
      expected_results.delete();
    end else begin
      // result side first: a beat leaving now belongs to an older event
      if (m_axis_tvalid && m_axis_tready) begin
        got.site = m_axis_tdata[SITE_BITS-1:0];
        got.tmo = m_axis_tdata[SITE_BITS +: OUT_TMO_BITS];
        got.start = m_axis_tuser;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with nothing expected: site %0d start %0b timeout %0d",
                     $realtime, got.site, got.start, got.tmo);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.site !== want.site || got.start !== want.start || got.tmo !== want.tmo) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result %0d: expected site %0d start %0b timeout %0d, got site %0d start %0b timeout %0d",
                       $realtime, checked, want.site, want.start, want.tmo,
                       got.site, got.start, got.tmo);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INITIAL_TIMEOUT: init_tmo = cfg_data;
          REG_RTT_UPPER_BOUND: upper_bound = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_event(s_axis_tuser,
                                                 s_axis_tdata[SAMPLE_BITS-1:0],
                                                 s_axis_tdata[SAMPLE_BITS +: SITE_BITS]));
    end
    pending = expected_results.size();
  end

endmodule

FILE: sim/tb.sv
module tb;
  import rtt_fm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam logic [SITE_BITS-1:0] SITE_BAD = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int EVENTS_PER_PHASE = 120;
  localparam int CYCLE_LIMIT = 300000;

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [S_TDATA_BITS-1:0] s_axis_tdata;
  logic [KIND_BITS-1:0]    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  int errors;
  int pending;
  int checked;
  bit src_idle;
  bit sink_idle;
  int events_sent;
  int ignored_sent;

  rtt_estimator_fault_monitor_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rtt_fm_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run timed out after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_event(input logic [KIND_BITS-1:0] kind,
                            input logic [SAMPLE_BITS-1:0] smp,
                            input logic [SITE_BITS-1:0] st);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {{(S_TDATA_BITS - SAMPLE_BITS - SITE_BITS){1'b0}}, st, smp};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (kind == KIND_WORKING || (kind != KIND_UNUSED && (st == SITE_OK || st == SITE_TEMP)))
      events_sent++;
    else
      ignored_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // block drained, then let the pipeline settle
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_event();
    logic [KIND_BITS-1:0]   kind;
    logic [SITE_BITS-1:0]   st;
    logic [SAMPLE_BITS-1:0] smp;
    int r;
    r = $urandom_range(0, 99);
    kind = (r < 60) ? KIND_SAMPLE : (r < 78) ? KIND_TIMEOUT :
           (r < 92) ? KIND_WORKING : KIND_UNUSED;
    r = $urandom_range(0, 99);
    st = (r < 45) ? SITE_OK : (r < 85) ? SITE_TEMP : (r < 93) ? SITE_PERM : SITE_BAD;
    r = $urandom_range(0, 99);
    if (r < 8)
      smp = '0;
    else if (r < 45)
      smp = SAMPLE_BITS'($urandom_range(1, 2000));
    else if (r < 75)
      smp = SAMPLE_BITS'($urandom_range(0, 65535));
    else if (r < 90)
      smp = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    else
      smp = SAMPLE_BITS'($urandom_range(60000, 70000));
    send_event(kind, smp, st);
  endtask

  initial begin
    logic [CFG_BITS-1:0] init_vals[NUM_PHASES];
    logic [CFG_BITS-1:0] bound_vals[NUM_PHASES];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_WORKING;
    cfg_valid = 1'b0;
    cfg_index = REG_INITIAL_TIMEOUT;
    cfg_data = '0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    events_sent = 0;
    ignored_sent = 0;

    init_vals[1] = '0;
    bound_vals[1] = '1;
    init_vals[2] = '1;
    bound_vals[2] = '0;
    init_vals[3] = CFG_BITS'($urandom_range(0, 65535));
    bound_vals[3] = CFG_BITS'($urandom_range(0, 65535));
    init_vals[4] = CFG_BITS'($urandom_range(0, 65535));
    bound_vals[4] = CFG_BITS'($urandom_range(1, 500));
    init_vals[5] = CFG_BITS'($urandom_range(0, 65535));
    bound_vals[5] = CFG_BITS'($urandom_range(2000, 65535));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed events at the reset settings
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_event(KIND_TIMEOUT, 20'd0, SITE_OK);
    send_event(KIND_SAMPLE, 20'd1000, SITE_OK);
    send_event(KIND_SAMPLE, 20'hFFFFF, SITE_TEMP);
    send_event(KIND_SAMPLE, 20'd0, SITE_OK);
    send_event(KIND_SAMPLE, 20'hAAAAA, SITE_TEMP);
    send_event(KIND_SAMPLE, 20'h55555, SITE_OK);
    send_event(KIND_TIMEOUT, 20'hFFFFF, SITE_TEMP);
    send_event(KIND_TIMEOUT, 20'd7, SITE_PERM);
    send_event(KIND_SAMPLE, 20'd500, SITE_PERM);
    send_event(KIND_SAMPLE, 20'd500, SITE_BAD);
    send_event(KIND_TIMEOUT, 20'd0, SITE_BAD);
    send_event(KIND_UNUSED, 20'hFFFFF, SITE_OK);
    send_event(KIND_UNUSED, 20'd0, SITE_TEMP);
    send_event(KIND_WORKING, 20'd0, SITE_PERM);
    send_event(KIND_WORKING, 20'hFFFFF, SITE_BAD);
    // zero average: a zero sample keeps it zero, the next one seeds again
    send_event(KIND_SAMPLE, 20'd0, SITE_OK);
    send_event(KIND_SAMPLE, 20'd1, SITE_TEMP);
    send_event(KIND_SAMPLE, 20'd30000, SITE_OK);
    send_event(KIND_SAMPLE, 20'd30001, SITE_OK);
    send_event(KIND_WORKING, 20'd0, SITE_OK);
    send_event(KIND_TIMEOUT, 20'd0, SITE_OK);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int target;
      if (ph > 0) begin
        wait_drained();
        write_reg(REG_INITIAL_TIMEOUT, init_vals[ph]);
        write_reg(REG_RTT_UPPER_BOUND, bound_vals[ph]);
        if (ph == 2) begin
          send_event(KIND_WORKING, 20'd0, SITE_OK);
          send_event(KIND_SAMPLE, 20'hFFFFF, SITE_OK);
        end
      end
      src_idle = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_idle = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      target = events_sent + EVENTS_PER_PHASE;
      while (events_sent < target) random_event();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("sent %0d effective and %0d ignored events over %0d register settings",
             events_sent, ignored_sent, NUM_PHASES);
    $display("compared %0d result beats, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rtt_fm_pkg.sv
rtl/core/rtt_estimator_fault_monitor_core.sv
rtl/core/rtt_fm_checker.sv
sim/rtt_fm_checker.sv
sim/tb.sv
